/* design/stq_pkg.sv */
// stq_pkg: shared types and constants of the sql text literal quoter
// no dependencies; used by the interfaces, stq_expand, stq_serializer and the top level
`default_nettype none

package stq_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_OUT = 8;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
  localparam int unsigned BODY_N  = 6;
  localparam int unsigned BODY_W  = $clog2(BODY_N + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_SPLIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JSON_MODE  = 1'd1;

  // characters that steer the quoting
  localparam logic [BYTE_W-1:0] CH_DQ = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQ = 8'h27;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_NL = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    QM_OUT  = 2'd0,
    QM_IN   = 2'd1,
    QM_PEND = 2'd2,
    QM_NL   = 2'd3
  } qmode_t;

  // characters produced for one input beat, lowest index leaves first
  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]               cnt;
    logic                           has_end;
    qmode_t                         qm_nxt;
  } stq_expand_t;

endpackage

`default_nettype wire

/* design/stq_if.sv */
// stq_in_if / stq_out_if: valid-ready channels of the quoter
// depends on stq_pkg for the byte width
`default_nettype none

interface stq_in_if;
  logic                       valid;
  logic                       ready;
  logic [stq_pkg::BYTE_W-1:0] text_byte;
  logic                       first_byte;
  logic                       last_byte;

  modport source (output valid, text_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, first_byte, last_byte, output ready);
endinterface

interface stq_out_if;
  logic                       valid;
  logic                       ready;
  logic [stq_pkg::BYTE_W-1:0] out_byte;
  logic                       out_end;

  modport source (output valid, out_byte, out_end, input ready);
  modport sink   (input valid, out_byte, out_end, output ready);
endinterface

`default_nettype wire

/* design/sql_text_literal_quoter.sv */
// sql_text_literal_quoter: top level, input register, quote state and configuration registers
// depends on stq_pkg, stq_if, stq_expand and stq_serializer
//
// Takes SQL text one byte per beat and emits one C or JSON string literal, one character per
// beat. A byte is registered, expanded into its characters (at most eight) and parked in a
// result register that drains one character per cycle while the receiver is ready. Plain
// text streams at one byte per cycle while the receiver is ready; an item that yields more
// characters holds further input back until the result register has drained. An item may
// also yield nothing (a dropped space). line_split and json_mode may be written only while
// no item is in flight; they apply from the next item on.
`default_nettype none

module sql_text_literal_quoter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  stq_in_if.sink                              in_ch,
  stq_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [stq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [stq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                       s1_valid_r;
  logic [stq_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_first_r;
  logic                       s1_last_r;
  stq_pkg::qmode_t            quote_mode_r;
  logic                       line_split_r;
  logic                       json_mode_r;

  stq_pkg::stq_expand_t       exp_res;
  logic                       ser_free;
  logic                       advance;
  logic                       accept;

  assign advance     = s1_valid_r && ser_free;
  assign in_ch.ready = !s1_valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  stq_expand u_expand (
    .text_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .last_byte  (s1_last_r),
    .quote_mode (quote_mode_r),
    .line_split (line_split_r),
    .json_mode  (json_mode_r),
    .result     (exp_res)
  );

  stq_serializer u_serializer (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance),
    .exp_in (exp_res),
    .free   (ser_free),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      quote_mode_r <= stq_pkg::QM_OUT;
      line_split_r <= 1'b0;
      json_mode_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        quote_mode_r <= exp_res.qm_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          stq_pkg::REG_LINE_SPLIT: line_split_r <= cfg_wdata[0];
          stq_pkg::REG_JSON_MODE:  json_mode_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      s1_byte_r  <= in_ch.text_byte;
      s1_first_r <= in_ch.first_byte;
      s1_last_r  <= in_ch.last_byte;
    end
  end

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && !$past(!rst_n)) |=> (quote_mode_r == $past(quote_mode_r)))
    else $error("quote state moved without a beat");

  a_closed_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> (quote_mode_r == stq_pkg::QM_OUT))
    else $error("quote state not cleared after closing quote");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("registered byte lost while stalled");

endmodule

`default_nettype wire

/* design/stq_expand.sv */
// stq_expand: maps one registered input byte and the quote state to its output characters
// depends on stq_pkg (types, characters)
`default_nettype none

module stq_expand (
  input  wire logic [stq_pkg::BYTE_W-1:0] text_byte,
  input  wire logic                       first_byte,
  input  wire logic                       last_byte,
  input  stq_pkg::qmode_t                 quote_mode,
  input  wire logic                       line_split,
  input  wire logic                       json_mode,
  output stq_pkg::stq_expand_t            result
);

  localparam logic [7:0] ESC_A = "a";
  localparam logic [7:0] ESC_B = "b";
  localparam logic [7:0] ESC_F = "f";
  localparam logic [7:0] ESC_N = "n";
  localparam logic [7:0] ESC_R = "r";
  localparam logic [7:0] ESC_T = "t";
  localparam logic [7:0] ESC_V = "v";
  localparam logic [7:0] ESC_U = "u";
  localparam logic [7:0] ESC_X = "x";
  localparam logic [7:0] ESC_0 = "0";

  typedef struct packed {
    logic [stq_pkg::BODY_N-1:0][stq_pkg::BYTE_W-1:0] b;
    logic [stq_pkg::BODY_W-1:0]                      n;
  } esc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] base;
    base = (v < 4'd10) ? 8'h30 : 8'h57;
    return {4'b0000, v} + base;
  endfunction

  function automatic esc_t escape(input logic [7:0] c, input logic json);
    esc_t       r;
    logic [7:0] e;
    r = '0;
    e = 8'h00;
    case (c)
      stq_pkg::CH_DQ: e = stq_pkg::CH_DQ;
      stq_pkg::CH_BS: e = stq_pkg::CH_BS;
      8'h08:          e = ESC_B;
      8'h0c:          e = ESC_F;
      stq_pkg::CH_NL: e = ESC_N;
      8'h0d:          e = ESC_R;
      8'h09:          e = ESC_T;
      8'h07:          e = json ? 8'h00 : ESC_A;
      8'h0b:          e = json ? 8'h00 : ESC_V;
      default:        e = 8'h00;
    endcase
    if (e != 8'h00) begin
      r.b[0] = stq_pkg::CH_BS;
      r.b[1] = e;
      r.n    = 3'd2;
    end else if (json && c < 8'd32) begin
      r.b[0] = stq_pkg::CH_BS;
      r.b[1] = ESC_U;
      r.b[2] = ESC_0;
      r.b[3] = ESC_0;
      r.b[4] = hex_digit(c[7:4]);
      r.b[5] = hex_digit(c[3:0]);
      r.n    = 3'd6;
    end else if (!json && (c < 8'd32 || c >= 8'd128)) begin
      r.b[0] = stq_pkg::CH_BS;
      r.b[1] = ESC_X;
      r.b[2] = hex_digit(c[7:4]);
      r.b[3] = hex_digit(c[3:0]);
      r.n    = 3'd4;
    end else begin
      r.b[0] = c;
      r.n    = 3'd1;
    end
    return r;
  endfunction

  esc_t                                            esc;
  stq_pkg::qmode_t                                 qm0;
  stq_pkg::qmode_t                                 nm;
  logic                                            do_out;
  logic                                            pre_nl;
  logic [stq_pkg::BODY_N-1:0][stq_pkg::BYTE_W-1:0] body;
  logic [stq_pkg::BODY_W-1:0]                      bn;
  logic [1:0][stq_pkg::BYTE_W-1:0]                 suf;
  logic [1:0]                                      sn;
  logic [stq_pkg::CNT_W-1:0]                       pn;
  logic [stq_pkg::CNT_W-1:0]                       pos;
  logic [stq_pkg::CNT_W-1:0]                       off_b;
  logic [stq_pkg::CNT_W-1:0]                       off_s;

  always_comb begin
    esc    = escape(text_byte, json_mode);
    qm0    = first_byte ? stq_pkg::QM_OUT : quote_mode;
    nm     = qm0;
    do_out = 1'b0;
    pre_nl = 1'b0;
    body   = '0;
    bn     = '0;
    suf    = '0;
    sn     = 2'd0;

    case (qm0)
      stq_pkg::QM_OUT: begin
        do_out = 1'b1;
      end
      stq_pkg::QM_IN: begin
        if (text_byte == stq_pkg::CH_SQ) begin
          body[0] = stq_pkg::CH_SQ;
          bn      = 3'd1;
          nm      = stq_pkg::QM_PEND;
        end else begin
          body = esc.b;
          bn   = esc.n;
        end
      end
      stq_pkg::QM_PEND: begin
        if (text_byte == stq_pkg::CH_SQ) begin
          body[0] = stq_pkg::CH_SQ;
          bn      = 3'd1;
          nm      = stq_pkg::QM_IN;
        end else begin
          do_out = 1'b1;
        end
      end
      stq_pkg::QM_NL: begin
        // spaces after a newline: kept as indent or dropped
        if (text_byte == stq_pkg::CH_SP) begin
          if (line_split) begin
            body[0] = stq_pkg::CH_SP;
            bn      = 3'd1;
          end
        end else begin
          pre_nl = line_split;
          do_out = 1'b1;
        end
      end
      default: begin
        do_out = 1'b1;
      end
    endcase

    if (do_out) begin
      nm = stq_pkg::QM_OUT;
      if (text_byte == stq_pkg::CH_SQ) begin
        body[0] = stq_pkg::CH_SQ;
        bn      = 3'd1;
        nm      = stq_pkg::QM_IN;
      end else if (text_byte == stq_pkg::CH_NL) begin
        nm = stq_pkg::QM_NL;
        if (line_split) begin
          body[0] = stq_pkg::CH_SP;
          body[1] = stq_pkg::CH_DQ;
          body[2] = stq_pkg::CH_NL;
          body[3] = stq_pkg::CH_SP;
          body[4] = stq_pkg::CH_SP;
          bn      = 3'd5;
        end else begin
          body[0] = stq_pkg::CH_SP;
          bn      = 3'd1;
        end
      end else begin
        body = esc.b;
        bn   = esc.n;
      end
    end

    if (last_byte) begin
      suf[0] = stq_pkg::CH_DQ;
      suf[1] = stq_pkg::CH_DQ;
      sn     = (nm == stq_pkg::QM_NL && line_split) ? 2'd2 : 2'd1;
      nm     = stq_pkg::QM_OUT;
    end

    // opening quote of the string, or reopening after a part break
    pn = {{(stq_pkg::CNT_W-1){1'b0}}, (first_byte || pre_nl)};

    result.bytes   = '0;
    result.cnt     = pn + {{(stq_pkg::CNT_W-stq_pkg::BODY_W){1'b0}}, bn}
                        + {{(stq_pkg::CNT_W-2){1'b0}}, sn};
    result.has_end = last_byte;
    result.qm_nxt  = nm;

    for (int i = 0; i < stq_pkg::MAX_OUT; i++) begin
      pos   = stq_pkg::CNT_W'(i);
      off_b = pos - pn;
      off_s = off_b - {{(stq_pkg::CNT_W-stq_pkg::BODY_W){1'b0}}, bn};
      if (pos < pn) begin
        result.bytes[i] = stq_pkg::CH_DQ;
      end else if (off_b < {{(stq_pkg::CNT_W-stq_pkg::BODY_W){1'b0}}, bn}) begin
        result.bytes[i] = body[off_b[stq_pkg::BODY_W-1:0]];
      end else if (off_s < {{(stq_pkg::CNT_W-2){1'b0}}, sn}) begin
        result.bytes[i] = suf[off_s[0]];
      end else begin
        result.bytes[i] = '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/stq_serializer.sv */
// stq_serializer: result register of one beat's characters; drains one a cycle while taken
// depends on stq_pkg (stq_expand_t) and stq_out_if
`default_nettype none

module stq_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  stq_pkg::stq_expand_t exp_in,
  output logic                 free,
  stq_out_if.source            out_ch
);

  logic [stq_pkg::MAX_OUT-1:0][stq_pkg::BYTE_W-1:0] buf_r, buf_nxt;
  logic [stq_pkg::CNT_W-1:0]                        cnt_r, cnt_nxt;
  logic                                             end_r, end_nxt;
  logic                                             take;

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_byte = buf_r[0];
  assign out_ch.out_end  = end_r && (cnt_r == stq_pkg::CNT_W'(1));
  assign take            = out_ch.valid && out_ch.ready;
  // room for a new beat once the last held character leaves
  assign free = (cnt_r == '0) || ((cnt_r == stq_pkg::CNT_W'(1)) && out_ch.ready);

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    if (load) begin
      buf_nxt = exp_in.bytes;
      cnt_nxt = exp_in.cnt;
      end_nxt = exp_in.has_end;
    end else if (take) begin
      buf_nxt = {{stq_pkg::BYTE_W{1'b0}}, buf_r[stq_pkg::MAX_OUT-1:1]};
      cnt_nxt = cnt_r - stq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    buf_r <= buf_nxt;
    end_r <= end_nxt;
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("beat loaded while characters still held");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stq_pkg::CNT_W'(stq_pkg::MAX_OUT))
    else $error("character count above buffer depth");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !load && cnt_r > stq_pkg::CNT_W'(1)) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("drain did not step by one character");

  a_end_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (load && exp_in.has_end) |-> (exp_in.cnt != '0))
    else $error("closing beat carries no characters");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench: self-checking bench for sql_text_literal_quoter, directed rows then random strings
// depends on stq_pkg, stq_if (stq_in_if, stq_out_if) and the quoter top level
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 12;
  localparam int PHASE_BEATS    = 24;

  localparam logic [7:0] C_BEL = 8'h07;
  localparam logic [7:0] C_BSP = 8'h08;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_VT  = 8'h0b;
  localparam logic [7:0] C_FF  = 8'h0c;
  localparam logic [7:0] C_CR  = 8'h0d;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } lit_char_t;

  typedef struct {
    logic [7:0] b;
    bit         f;
    bit         l;
    bit         ml;
    bit         jm;
    string      lit;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [stq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sql_text_literal_quoter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected literal characters, oldest first
  lit_char_t literal_q[$];
  // spelled-out literal per driven beat, empty when the quoting model decides
  string     typed_lit_q[$];
  dir_row_t  dir_rows[$];

  stq_pkg::qmode_t quote_st = stq_pkg::QM_OUT;
  bit     line_split_m = 1'b0;
  bit     json_mode_m  = 1'b0;

  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_strings = 0;
  int quiet_cycles = 0;
  int hold_len = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;

  // ---------------------------------------------------------------- literal model

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic fin);
    lit_char_t e;
    e.ch  = ch;
    e.fin = fin;
    literal_q.push_back(e);
  endfunction

  function automatic void emit_escaped(input logic [7:0] c);
    logic [7:0] e;
    e = 8'h00;
    case (c)
      stq_pkg::CH_DQ: e = stq_pkg::CH_DQ;
      stq_pkg::CH_BS: e = stq_pkg::CH_BS;
      C_BSP: e = "b";
      C_FF:  e = "f";
      stq_pkg::CH_NL: e = "n";
      C_CR:  e = "r";
      C_TAB: e = "t";
      C_BEL: e = json_mode_m ? 8'h00 : "a";
      C_VT:  e = json_mode_m ? 8'h00 : "v";
      default: ;
    endcase
    if (e != 8'h00) begin
      emit(stq_pkg::CH_BS, 1'b0);
      emit(e, 1'b0);
    end else if (json_mode_m && c < 8'd32) begin
      emit(stq_pkg::CH_BS, 1'b0);
      emit("u", 1'b0);
      emit("0", 1'b0);
      emit("0", 1'b0);
      emit(hex_digit(c[7:4]), 1'b0);
      emit(hex_digit(c[3:0]), 1'b0);
    end else if (!json_mode_m && (c < 8'd32 || c >= 8'd128)) begin
      emit(stq_pkg::CH_BS, 1'b0);
      emit("x", 1'b0);
      emit(hex_digit(c[7:4]), 1'b0);
      emit(hex_digit(c[3:0]), 1'b0);
    end else begin
      emit(c, 1'b0);
    end
  endfunction

  function automatic void emit_unquoted(input logic [7:0] c);
    if (c == stq_pkg::CH_SQ) begin
      emit(stq_pkg::CH_SQ, 1'b0);
      quote_st = stq_pkg::QM_IN;
    end else if (c == stq_pkg::CH_NL) begin
      emit(stq_pkg::CH_SP, 1'b0);
      if (line_split_m) begin
        emit(stq_pkg::CH_DQ, 1'b0);
        emit(stq_pkg::CH_NL, 1'b0);
        emit(stq_pkg::CH_SP, 1'b0);
        emit(stq_pkg::CH_SP, 1'b0);
      end
      quote_st = stq_pkg::QM_NL;
    end else begin
      emit_escaped(c);
    end
  endfunction

  function automatic void quote_byte(input logic [7:0] c, input logic f, input logic l);
    if (f) begin
      quote_st = stq_pkg::QM_OUT;
      emit(stq_pkg::CH_DQ, 1'b0);
    end
    case (quote_st)
      stq_pkg::QM_OUT: emit_unquoted(c);
      stq_pkg::QM_IN: begin
        if (c == stq_pkg::CH_SQ) begin
          emit(stq_pkg::CH_SQ, 1'b0);
          quote_st = stq_pkg::QM_PEND;
        end else begin
          emit_escaped(c);
        end
      end
      stq_pkg::QM_PEND: begin
        // doubled quote stays inside, anything else closes the sql string
        if (c == stq_pkg::CH_SQ) begin
          emit(stq_pkg::CH_SQ, 1'b0);
          quote_st = stq_pkg::QM_IN;
        end else begin
          quote_st = stq_pkg::QM_OUT;
          emit_unquoted(c);
        end
      end
      default: begin
        if (c == stq_pkg::CH_SP) begin
          if (line_split_m) emit(stq_pkg::CH_SP, 1'b0);
        end else begin
          if (line_split_m) emit(stq_pkg::CH_DQ, 1'b0);
          quote_st = stq_pkg::QM_OUT;
          emit_unquoted(c);
        end
      end
    endcase
    if (l) begin
      if (quote_st == stq_pkg::QM_NL && line_split_m) emit(stq_pkg::CH_DQ, 1'b0);
      emit(stq_pkg::CH_DQ, 1'b1);
      quote_st = stq_pkg::QM_OUT;
    end
  endfunction

  // ---------------------------------------------------------------- monitor and checker

  always @(posedge clk) begin : monitor
    string     lit;
    int        base;
    lit_char_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      lit  = typed_lit_q.pop_front();
      base = literal_q.size();
      quote_byte(in_ch.text_byte, in_ch.first_byte, in_ch.last_byte);
      if (lit.len() != 0) begin
        while (literal_q.size() > base) void'(literal_q.pop_back());
        for (int i = 0; i < lit.len(); i++)
          emit(lit[i], (i == lit.len() - 1) && in_ch.last_byte);
      end
      n_items++;
      if (in_ch.last_byte) n_strings++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (literal_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %h end %b", $time,
                 out_ch.out_byte, out_ch.out_end);
        n_errors++;
      end else begin
        want = literal_q.pop_front();
        if (out_ch.out_byte !== want.ch || out_ch.out_end !== want.fin) begin
          $display("%0t: mismatch, expected byte %h end %b, actual byte %h end %b", $time,
                   want.ch, want.fin, out_ch.out_byte, out_ch.out_end);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d characters pending", $time,
               quiet_cycles, literal_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      gap = (hold_len > 0) ? hold_len : (idle_out ? $urandom_range(0, 9) : 0);
      hold_len = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_beat(input logic [7:0] b, input bit f, input bit l, input int gap,
                           input string lit);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.text_byte  <= b;
    in_ch.first_byte <= f;
    in_ch.last_byte  <= l;
    typed_lit_q.push_back(lit);
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  function automatic int draw_gap();
    return idle_in ? $urandom_range(0, 9) : 0;
  endfunction

  // drain everything, then write both registers
  task automatic set_modes(input bit ml, input bit jm);
    in_ch.valid <= 1'b0;
    while (literal_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= stq_pkg::REG_LINE_SPLIT;
    cfg_wdata <= ml;
    @(negedge clk);
    cfg_index <= stq_pkg::REG_JSON_MODE;
    cfg_wdata <= jm;
    @(negedge clk);
    cfg_we <= 1'b0;
    line_split_m = ml;
    json_mode_m  = jm;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(33, 126));
    if (r < 55) return stq_pkg::CH_SP;
    if (r < 63) return stq_pkg::CH_NL;
    if (r < 73) return stq_pkg::CH_SQ;
    if (r < 80) return 8'($urandom_range(1, 31));
    if (r < 87) return 8'($urandom_range(128, 255));
    if (r < 91) return stq_pkg::CH_DQ;
    if (r < 94) return stq_pkg::CH_BS;
    if (r < 96) return (r == 94) ? C_BEL : C_VT;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_string(input int len, input bit with_first, input bit with_last);
    for (int i = 0; i < len; i++)
      send_beat(pick_text_byte(), with_first && i == 0, with_last && i == len - 1,
                draw_gap(), "");
  endtask

  function automatic void add_row(input logic [7:0] b, input bit f, input bit l,
                                  input bit ml, input bit jm, input string lit);
    dir_row_t r;
    r.b   = b;
    r.f   = f;
    r.l   = l;
    r.ml  = ml;
    r.jm  = jm;
    r.lit = lit;
    dir_rows.push_back(r);
  endfunction

  initial begin : stimulus
    bit ml;
    bit jm;
    int sent;
    int len;
    int noise;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.text_byte  = 8'h41;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = stq_pkg::REG_LINE_SPLIT;
    cfg_wdata        = '0;

    // reset settings: c escapes, single line
    add_row("A",   1, 1, 0, 0, "\"A\"");
    add_row(8'hff, 1, 1, 0, 0, "\"\\xff\"");
    add_row(8'h01, 1, 1, 0, 0, "\"\\x01\"");
    add_row(C_BEL, 1, 1, 0, 0, "\"\\a\"");
    // quoted sql with a doubled quote, then a byte after a pending quote
    add_row(stq_pkg::CH_SQ, 1, 0, 0, 0, "");
    add_row("a",   0, 0, 0, 0, "");
    add_row(stq_pkg::CH_SQ, 0, 0, 0, 0, "");
    add_row(stq_pkg::CH_SQ, 0, 0, 0, 0, "");
    add_row("b",   0, 0, 0, 0, "");
    add_row(stq_pkg::CH_SQ, 0, 0, 0, 0, "");
    add_row(";",   0, 1, 0, 0, "");
    // unquoted newline folds to a space and eats the indent
    add_row(stq_pkg::CH_NL, 1, 0, 0, 0, "");
    add_row(stq_pkg::CH_SP, 0, 0, 0, 0, "");
    add_row(stq_pkg::CH_SP, 0, 0, 0, 0, "");
    add_row("x",   0, 0, 0, 0, "");
    add_row(stq_pkg::CH_NL, 0, 1, 0, 0, "");
    // json escapes, multi-line parts
    add_row(8'h01, 1, 1, 1, 1, "\"\\u0001\"");
    add_row(8'h80, 1, 1, 1, 1, "");
    add_row(stq_pkg::CH_NL, 1, 0, 1, 1, "");
    add_row(stq_pkg::CH_SP, 0, 0, 1, 1, "");
    add_row("y",   0, 0, 1, 1, "");
    add_row(stq_pkg::CH_NL, 0, 0, 1, 1, "");
    add_row(stq_pkg::CH_SP, 0, 1, 1, 1, "");
    // abandoned quoted string, then a byte with no first mark
    add_row(stq_pkg::CH_SQ, 1, 0, 1, 1, "");
    add_row("z",   1, 1, 1, 1, "");
    add_row("q",   0, 1, 1, 1, "");

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].ml != line_split_m || dir_rows[i].jm != json_mode_m)
        set_modes(dir_rows[i].ml, dir_rows[i].jm);
      send_beat(dir_rows[i].b, dir_rows[i].f, dir_rows[i].l, draw_gap(), dir_rows[i].lit);
    end

    for (int ph = 0; ph < 8; ph++) begin
      ml = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      jm = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
      set_modes(ml, jm);
      idle_in  = (ph == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      idle_out = (ph == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // receiver holds off while input streams, so the block backs up
        idle_in  = 1'b0;
        hold_len = HOLD_CYCLES;
        send_string(24, 1, 1);
        idle_in  = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BEATS) begin
        len   = $urandom_range(1, 12);
        noise = $urandom_range(0, 9);
        // mostly well-formed strings, some with a missing first or last mark
        send_string(len, noise != 0, noise != 1);
        sent += len;
      end
    end

    in_ch.valid <= 1'b0;
    while (literal_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d text beats in %0d closed strings, %0d literal characters checked",
             n_items, n_strings, n_results);
    $display("run: all four escape and line modes, %0d-cycle output hold-off, random idling",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
